### sv/hfcp_pkg.sv
// package for the hangul final consonant particle select unit
// word types, queue entry type, particle kinds and decode constants
// no dependencies
`default_nettype none

package hfcp_pkg;

    localparam int CP_W = 21;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       word_end;
        logic [2:0] particle_kind;
    } text_word_t;

    typedef struct packed {
        logic [CP_W-1:0] last_code_point;
        logic            is_hangul_syllable;
        logic [4:0]      final_index;
        logic            has_final;
        logic            final_is_rieul;
        logic            consonant_form;
    } result_word_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic [2:0]      particle_kind;
    } item_t;

    typedef enum logic [2:0] {
        KIND_EUL_REUL = 3'd0,
        KIND_I_GA     = 3'd1,
        KIND_EUN_NEUN = 3'd2,
        KIND_GWA_WA   = 3'd3,
        KIND_EURO_RO  = 3'd4
    } particle_kind_t;

    localparam logic [CP_W-1:0] HANGUL_FIRST = 21'h00AC00;
    localparam logic [CP_W-1:0] HANGUL_LAST  = 21'h00D7A3;
    localparam logic [4:0]      FINAL_RIEUL  = 5'd8;
    localparam logic [4:0]      LAST_FINAL   = 5'd27;

    // x / 7 = (x * MOD7_RECIP) >> MOD7_SHIFT, exact for x below 6241
    localparam logic [15:0]     MOD7_RECIP   = 16'd37450;
    localparam int              MOD7_SHIFT   = 18;

    localparam logic [1:0]      CONT_TAG     = 2'b10;

endpackage

`default_nettype wire

### sv/hfcp_if.sv
// stream interfaces for text bytes and result words
// depends on hfcp_pkg
`default_nettype none

interface hfcp_text_if;
    logic                   valid;
    logic                   ready;
    hfcp_pkg::text_word_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hfcp_result_if;
    logic                   valid;
    logic                   ready;
    hfcp_pkg::result_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### sv/hfcp_front.sv
// front end: utf-8 decoder that takes one byte per cycle while the queue has room
// pushes the decoded last code point and particle kind at word end; uses hfcp_pkg
`default_nettype none

module hfcp_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    hfcp_text_if.sink            text,
    output hfcp_pkg::item_t      push_item,
    output logic                 push_valid,
    input  wire logic            push_ready
);
    import hfcp_pkg::*;

    logic [CP_W-1:0] accum_reg;
    logic [CP_W-1:0] accum_next;
    logic [1:0]      pending_reg;
    logic [1:0]      pending_next;
    logic            invalid_reg;
    logic            invalid_next;
    logic [CP_W-1:0] cp;
    logic [7:0]      b;
    logic            take;

    assign b    = text.data.text_byte;
    assign take = text.valid & text.ready;

    // byte decode
    always_comb
    begin
        accum_next   = accum_reg;
        pending_next = pending_reg;
        invalid_next = invalid_reg;
        if (b[7:6] == CONT_TAG)
        begin
            if (pending_reg != 2'd0 && !invalid_reg)
            begin
                accum_next   = {accum_reg[CP_W-7:0], b[5:0]};
                pending_next = pending_reg - 2'd1;
            end
        end
        else
        begin
            invalid_next = 1'b0;
            case (b) inside
                [8'h00:8'h7F]:
                begin
                    accum_next   = {13'd0, b};
                    pending_next = 2'd0;
                end
                [8'hC0:8'hDF]:
                begin
                    accum_next   = {16'd0, b[4:0]};
                    pending_next = 2'd1;
                end
                [8'hE0:8'hEF]:
                begin
                    accum_next   = {17'd0, b[3:0]};
                    pending_next = 2'd2;
                end
                [8'hF0:8'hF7]:
                begin
                    accum_next   = {18'd0, b[2:0]};
                    pending_next = 2'd3;
                end
                default:
                begin
                    accum_next   = '0;
                    pending_next = 2'd0;
                    invalid_next = 1'b1;
                end
            endcase
        end
    end

    // missing continuation groups read as zero
    always_comb
    begin
        case (pending_next)
            2'd0:    cp = accum_next;
            2'd1:    cp = {accum_next[CP_W-7:0], 6'd0};
            2'd2:    cp = {accum_next[CP_W-13:0], 12'd0};
            default: cp = {accum_next[CP_W-19:0], 18'd0};
        endcase
        if (invalid_next)
        begin
            cp = '0;
        end
    end

    assign text.ready              = push_ready;
    assign push_valid              = text.valid & text.data.word_end;
    assign push_item.code_point    = cp;
    assign push_item.particle_kind = text.data.particle_kind;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg   <= '0;
            pending_reg <= 2'd0;
            invalid_reg <= 1'b1;
        end
        else if (take)
        begin
            if (text.data.word_end)
            begin
                accum_reg   <= '0;
                pending_reg <= 2'd0;
                invalid_reg <= 1'b1;
            end
            else
            begin
                accum_reg   <= accum_next;
                pending_reg <= pending_next;
                invalid_reg <= invalid_next;
            end
        end
    end

endmodule

`default_nettype wire

### sv/hfcp_fifo.sv
// two-entry queue between decoder front end and classifier back end
// uses hfcp_pkg item_t
`default_nettype none

module hfcp_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hfcp_pkg::item_t push_item,
    input  wire logic            push_valid,
    output logic                 push_ready,
    output hfcp_pkg::item_t      pop_item,
    output logic                 pop_valid,
    input  wire logic            pop_ready
);
    import hfcp_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid & push_ready;
    assign pop        = pop_valid & pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule

`default_nettype wire

### sv/hfcp_back.sv
// back end: hangul range check, final index by mod 28, particle form
// two registered stages, the second being the result register; uses hfcp_pkg
`default_nettype none

module hfcp_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire hfcp_pkg::item_t pop_item,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    hfcp_result_if.source        result
);
    import hfcp_pkg::*;

    // stage a
    logic            a_valid_reg;
    logic [CP_W-1:0] a_cp_reg;
    logic [2:0]      a_kind_reg;
    logic            a_hangul_reg;
    logic [11:0]     a_quad_reg;
    logic [1:0]      a_low_reg;
    logic [9:0]      a_q7_reg;
    logic            a_ready;

    logic [CP_W-1:0] diff;
    logic [27:0]     prod;
    logic            hangul;

    // stage b
    logic            out_ready;
    logic [12:0]     q7_times;
    logic [12:0]     rem_wide;
    logic [4:0]      idx;
    logic            fin;
    logic            rieul;
    result_word_t    res_reg;
    logic            res_valid_reg;

    assign out_ready = ~res_valid_reg | result.ready;
    assign a_ready   = ~a_valid_reg | out_ready;
    assign pop_ready = a_ready;

    assign hangul = (pop_item.code_point >= HANGUL_FIRST) &&
                    (pop_item.code_point <= HANGUL_LAST);
    assign diff   = pop_item.code_point - HANGUL_FIRST;
    // (diff / 4) / 7 by reciprocal
    assign prod   = diff[13:2] * MOD7_RECIP;

    always_ff @(posedge clk)
    begin
        if (pop_valid && a_ready)
        begin
            a_cp_reg     <= pop_item.code_point;
            a_kind_reg   <= pop_item.particle_kind;
            a_hangul_reg <= hangul;
            a_quad_reg   <= diff[13:2];
            a_low_reg    <= diff[1:0];
            a_q7_reg     <= prod[27:MOD7_SHIFT];
        end
    end

    // remainder mod 7 of the quarter, index = rem * 4 + low bits
    assign q7_times = {a_q7_reg, 3'd0} - {3'd0, a_q7_reg};
    assign rem_wide = {1'b0, a_quad_reg} - q7_times;
    assign idx      = a_hangul_reg ? {rem_wide[2:0], a_low_reg} : 5'd0;
    assign fin      = (idx != 5'd0);
    assign rieul    = (idx == FINAL_RIEUL);

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && out_ready)
        begin
            res_reg.last_code_point    <= a_cp_reg;
            res_reg.is_hangul_syllable <= a_hangul_reg;
            res_reg.final_index        <= idx;
            res_reg.has_final          <= fin;
            res_reg.final_is_rieul     <= rieul;
            res_reg.consonant_form     <= fin & ~((a_kind_reg == KIND_EURO_RO) & rieul);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= pop_valid;
            end
            if (out_ready)
            begin
                res_valid_reg <= a_valid_reg;
            end
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

endmodule

`default_nettype wire

### sv/hangul_final_consonant_particle_select_unit.sv
// takes one utf-8 text byte per cycle, one byte accepted every cycle when the result side drains
// a word's result passes through the queue entry, stage a and the result register before it shows on the result port
// path: decoder front end, two-entry queue, two-stage classifier with mod 28 multiply
// reset clears decoder state, queue and pipeline valids; no clearing pass
// depends on hfcp_pkg, hfcp_if, hfcp_front, hfcp_fifo, hfcp_back
`default_nettype none

module hangul_final_consonant_particle_select_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    hfcp_text_if.sink      text,
    hfcp_result_if.source  result
);
    import hfcp_pkg::*;

    item_t push_item;
    logic  push_valid;
    logic  push_ready;
    item_t pop_item;
    logic  pop_valid;
    logic  pop_ready;

    hfcp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    hfcp_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (push_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    hfcp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_item   (pop_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .result     (result)
    );

`ifndef SYNTHESIS
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.data.final_index <= LAST_FINAL))
        else $error("final index out of range");

    a_final_needs_hangul: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.has_final) |-> result.data.is_hangul_syllable)
        else $error("final consonant on non-hangul code point");

    a_hangul_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.is_hangul_syllable) |->
            (result.data.last_code_point >= HANGUL_FIRST &&
             result.data.last_code_point <= HANGUL_LAST))
        else $error("hangul flag outside syllable range");

    a_form_needs_final: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.consonant_form) |-> result.data.has_final)
        else $error("consonant form without final consonant");
`endif

endmodule

`default_nettype wire

### bench/hangul_final_consonant_particle_select_unit_tb.sv
// testbench for the hangul final consonant particle select unit: utf-8 words in,
// one checked result word per word end, with random idling on both channels
// depends on hfcp_pkg, hfcp_if and hangul_final_consonant_particle_select_unit
`default_nettype none

module hangul_final_consonant_particle_select_unit_tb;
    import hfcp_pkg::*;

    localparam int unsigned  TEXT_TARGET         = 1250;
    localparam int unsigned  IDLE_LIMIT          = 400;
    localparam int unsigned  DRAIN_CYCLES        = 8;
    localparam int unsigned  FINALS_PER_SYLLABLE = 28;
    localparam logic [2:0]   KIND_SPARE_LO       = 3'd5;
    localparam logic [2:0]   KIND_SPARE_HI       = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hfcp_text_if   text_ch ();
    hfcp_result_if result_ch ();

    hangul_final_consonant_particle_select_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch)
    );

    text_word_t   pending_text[$];
    result_word_t due_results[$];
    logic [7:0]   piece_bytes[$];

    // decoder state of the predictor
    logic [CP_W-1:0] acc_bits = '0;
    logic [1:0]      cont_left = '0;
    logic            no_lead = 1'b1;

    logic         text_taken = 1'b0;
    logic         result_taken = 1'b0;
    int unsigned  send_wait = 0;
    bit           send_burst = 1'b0;
    int unsigned  hold_left = 0;
    int unsigned  hold_next;
    bit           hold_burst = 1'b0;
    int unsigned  idle_cycles = 0;
    int unsigned  fail_count = 0;
    int unsigned  bytes_queued = 0;
    int unsigned  words_checked = 0;
    int unsigned  hangul_seen = 0;
    int unsigned  rieul_seen = 0;
    result_word_t predicted;
    result_word_t seen_word;
    result_word_t oldest_due;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit decode_byte(input text_word_t w, output result_word_t r);
        logic [CP_W-1:0] cp;
        logic [CP_W-1:0] offs;
        logic [4:0]      fin;
        r = '0;
        if (w.text_byte[7:6] == CONT_TAG)
        begin
            if (cont_left != 2'd0 && !no_lead)
            begin
                acc_bits  = {acc_bits[CP_W-7:0], w.text_byte[5:0]};
                cont_left = cont_left - 2'd1;
            end
        end
        else
        begin
            no_lead   = 1'b0;
            cont_left = 2'd0;
            casez (w.text_byte)
                8'b0???????:
                begin
                    acc_bits = {13'd0, w.text_byte};
                end
                8'b110?????:
                begin
                    acc_bits  = {16'd0, w.text_byte[4:0]};
                    cont_left = 2'd1;
                end
                8'b1110????:
                begin
                    acc_bits  = {17'd0, w.text_byte[3:0]};
                    cont_left = 2'd2;
                end
                8'b11110???:
                begin
                    acc_bits  = {18'd0, w.text_byte[2:0]};
                    cont_left = 2'd3;
                end
                default:
                begin
                    acc_bits = '0;
                    no_lead  = 1'b1;
                end
            endcase
        end
        if (!w.word_end)
            return 1'b0;

        // a cut-short code point gets zero bits for its missing groups
        cp = no_lead ? '0 : (acc_bits << (6 * cont_left));
        r.last_code_point = cp;
        if (cp >= HANGUL_FIRST && cp <= HANGUL_LAST)
        begin
            offs = cp - HANGUL_FIRST;
            fin  = 5'(offs % FINALS_PER_SYLLABLE);
            r.is_hangul_syllable = 1'b1;
            r.final_index        = fin;
            r.has_final          = (fin != 5'd0);
            r.final_is_rieul     = (fin == FINAL_RIEUL);
        end
        r.consonant_form = r.has_final;
        if (w.particle_kind == KIND_EURO_RO && r.final_is_rieul)
            r.consonant_form = 1'b0;

        acc_bits  = '0;
        cont_left = 2'd0;
        no_lead   = 1'b1;
        return 1'b1;
    endfunction

    function automatic int unsigned draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic logic [7:0] cont_byte();
        logic [7:0] c;
        c = 8'($urandom_range('h80, 'hBF));
        return c;
    endfunction

    function automatic logic [CP_W-1:0] hangul_cp();
        int unsigned off;
        int unsigned fin;
        fin = ($urandom_range(0, 3) == 0) ? FINAL_RIEUL : $urandom_range(0, 27);
        off = $urandom_range(0, 398) * FINALS_PER_SYLLABLE + fin;
        return HANGUL_FIRST + off[CP_W-1:0];
    endfunction

    task automatic push_text(input logic [7:0] b, input logic last, input logic [2:0] kind);
        text_word_t w;
        w.text_byte     = b;
        w.word_end      = last;
        w.particle_kind = last ? kind : 3'($urandom_range(0, 7));
        pending_text.push_back(w);
        bytes_queued++;
    endtask

    task automatic encode_cp(input logic [CP_W-1:0] cp);
        if (cp < 'h80)
            piece_bytes.push_back(cp[7:0]);
        else if (cp < 'h800)
        begin
            piece_bytes.push_back({3'b110, cp[10:6]});
            piece_bytes.push_back({CONT_TAG, cp[5:0]});
        end
        else if (cp < 'h10000)
        begin
            piece_bytes.push_back({4'b1110, cp[15:12]});
            piece_bytes.push_back({CONT_TAG, cp[11:6]});
            piece_bytes.push_back({CONT_TAG, cp[5:0]});
        end
        else
        begin
            piece_bytes.push_back({5'b11110, cp[20:18]});
            piece_bytes.push_back({CONT_TAG, cp[17:12]});
            piece_bytes.push_back({CONT_TAG, cp[11:6]});
            piece_bytes.push_back({CONT_TAG, cp[5:0]});
        end
    endtask

    task automatic flush_piece(input logic last, input logic [2:0] kind);
        for (int i = 0; i < piece_bytes.size(); i++)
            push_text(piece_bytes[i], last && (i == piece_bytes.size() - 1), kind);
        piece_bytes.delete();
    endtask

    task automatic push_cp_word(input logic [CP_W-1:0] cp, input logic [2:0] kind);
        encode_cp(cp);
        flush_piece(1'b1, kind);
    endtask

    task automatic gen_word();
        int unsigned pieces;
        int unsigned r;
        int unsigned cut;
        logic [2:0]  kind;
        pieces = $urandom_range(1, 3);
        if ($urandom_range(0, 9) < 8)
            kind = 3'($urandom_range(KIND_EUL_REUL, KIND_EURO_RO));
        else
            kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        for (int p = 0; p < pieces; p++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                encode_cp(hangul_cp());
            else if (r < 55)
                encode_cp(21'($urandom_range(0, 'h7F)));
            else if (r < 65)
                encode_cp(21'($urandom_range('h80, 'h7FF)));
            else if (r < 78)
                encode_cp(21'($urandom_range('h800, 'hFFFF)));
            else if (r < 85)
                encode_cp(21'($urandom_range('h10000, 'h1FFFFF)));
            else if (r < 88)
                piece_bytes.push_back(8'($urandom_range(0, 255)));
            else if (r < 92)
            begin
                // truncated sequence
                encode_cp(21'($urandom_range('h80, 'h1FFFFF)));
                cut = $urandom_range(1, piece_bytes.size() - 1);
                while (piece_bytes.size() > cut)
                    void'(piece_bytes.pop_back());
            end
            else if (r < 96)
            begin
                // stray continuations after a full code point
                encode_cp(21'($urandom_range(0, 'hFFFF)));
                repeat ($urandom_range(1, 2))
                    piece_bytes.push_back(cont_byte());
            end
            else
            begin
                piece_bytes.push_back(8'($urandom_range('hF8, 'hFF)));
                repeat ($urandom_range(0, 2))
                    piece_bytes.push_back(cont_byte());
            end
            flush_piece(p == pieces - 1, kind);
        end
    endtask

    // text source
    always @(negedge clk)
    begin
        if (!rst_n)
            text_ch.valid <= 1'b0;
        else if (!text_ch.valid || text_taken)
        begin
            if (send_wait != 0)
            begin
                send_wait     <= send_wait - 1;
                text_ch.valid <= 1'b0;
            end
            else if (pending_text.size() != 0)
            begin
                text_ch.data  <= pending_text.pop_front();
                text_ch.valid <= 1'b1;
                send_wait     <= draw_gap(send_burst);
                if ($urandom_range(0, 40) == 0)
                    send_burst <= !send_burst;
            end
            else
                text_ch.valid <= 1'b0;
        end
    end

    // result sink stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_taken)
            begin
                hold_next = draw_gap(hold_burst);
                if ($urandom_range(0, 40) == 0)
                    hold_burst <= !hold_burst;
            end
            else
                hold_next = hold_left;
            if (hold_next != 0)
            begin
                result_ch.ready <= 1'b0;
                hold_left       <= hold_next - 1;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                hold_left       <= 0;
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        text_taken   <= rst_n && text_ch.valid && text_ch.ready;
        result_taken <= rst_n && result_ch.valid && result_ch.ready;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                seen_word = result_ch.data;
                if (due_results.size() == 0)
                begin
                    $error("result word %h with no expectation", seen_word);
                    fail_count++;
                end
                else
                begin
                    oldest_due = due_results.pop_front();
                    words_checked++;
                    if (seen_word.last_code_point !== oldest_due.last_code_point)
                    begin
                        $error("last_code_point: expected %h, got %h",
                               oldest_due.last_code_point, seen_word.last_code_point);
                        fail_count++;
                    end
                    if (seen_word.is_hangul_syllable !== oldest_due.is_hangul_syllable)
                    begin
                        $error("is_hangul_syllable: expected %b, got %b",
                               oldest_due.is_hangul_syllable, seen_word.is_hangul_syllable);
                        fail_count++;
                    end
                    if (seen_word.final_index !== oldest_due.final_index)
                    begin
                        $error("final_index: expected %0d, got %0d",
                               oldest_due.final_index, seen_word.final_index);
                        fail_count++;
                    end
                    if (seen_word.has_final !== oldest_due.has_final)
                    begin
                        $error("has_final: expected %b, got %b",
                               oldest_due.has_final, seen_word.has_final);
                        fail_count++;
                    end
                    if (seen_word.final_is_rieul !== oldest_due.final_is_rieul)
                    begin
                        $error("final_is_rieul: expected %b, got %b",
                               oldest_due.final_is_rieul, seen_word.final_is_rieul);
                        fail_count++;
                    end
                    if (seen_word.consonant_form !== oldest_due.consonant_form)
                    begin
                        $error("consonant_form: expected %b, got %b",
                               oldest_due.consonant_form, seen_word.consonant_form);
                        fail_count++;
                    end
                end
            end
            if (text_ch.valid && text_ch.ready)
            begin
                if (decode_byte(text_ch.data, predicted))
                begin
                    due_results.push_back(predicted);
                    if (predicted.is_hangul_syllable)
                        hangul_seen++;
                    if (predicted.final_is_rieul)
                        rieul_seen++;
                end
            end
            if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= IDLE_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
                $display("Some tests failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        text_ch.valid   = 1'b0;
        text_ch.data    = '0;
        result_ch.ready = 1'b0;

        push_cp_word('h41, KIND_EUL_REUL);
        push_cp_word('h00, KIND_I_GA);
        push_cp_word('h7F, KIND_EURO_RO);
        push_cp_word(HANGUL_FIRST, KIND_EUL_REUL);
        push_cp_word(HANGUL_LAST, KIND_I_GA);
        push_cp_word(HANGUL_FIRST + FINAL_RIEUL, KIND_EURO_RO);
        push_cp_word(HANGUL_FIRST + FINAL_RIEUL, KIND_GWA_WA);
        push_cp_word(HANGUL_FIRST - 21'd1, KIND_EUN_NEUN);
        push_cp_word(HANGUL_LAST + 21'd1, KIND_EURO_RO);
        push_cp_word('h1FFFFF, KIND_SPARE_HI);
        // invalid lead, lone continuation, truncated, continuation after invalid lead
        push_text(8'hFF, 1'b1, KIND_SPARE_LO);
        push_text(8'h80, 1'b1, KIND_SPARE_HI);
        push_text(8'hF4, 1'b0, KIND_GWA_WA);
        push_text(8'h8F, 1'b1, KIND_GWA_WA);
        push_text(8'hF8, 1'b0, KIND_EUL_REUL);
        push_text(8'hBF, 1'b1, KIND_EUL_REUL);
        // continuation past the declared count
        push_text(8'hC3, 1'b0, KIND_EUN_NEUN);
        push_text(8'hA9, 1'b0, KIND_EUN_NEUN);
        push_text(8'hBF, 1'b1, KIND_EUN_NEUN);

        while (bytes_queued < TEXT_TARGET)
            gen_word();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (pending_text.size() != 0 || text_ch.valid);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (due_results.size() != 0)
        begin
            $error("%0d expected result words never arrived", due_results.size());
            fail_count++;
        end
        $display("sent %0d text bytes, checked %0d result words", bytes_queued, words_checked);
        $display("hangul syllables: %0d, rieul finals among them: %0d", hangul_seen, rieul_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
sv/hfcp_pkg.sv
sv/hfcp_if.sv
sv/hfcp_front.sv
sv/hfcp_fifo.sv
sv/hfcp_back.sv
sv/hangul_final_consonant_particle_select_unit.sv
bench/hangul_final_consonant_particle_select_unit_tb.sv
